/* hw/rtl/tcd_pkg.sv */
package tcd_pkg;

    localparam int PITCH_W     = 16;
    localparam int DIFF_W      = PITCH_W + 1;
    localparam int TIME_W      = 32;
    localparam int TIMEOUT_W   = 16;
    localparam int ALPHA_W     = 17;
    localparam int ALPHA_SHIFT = 16;
    localparam int PROD_W      = PITCH_W + ALPHA_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;

    localparam logic [ALPHA_W-1:0]   ALPHA_ONE         = 17'h10000;
    localparam logic [ALPHA_W-1:0]   ALPHA_RESET       = 17'd6554;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 16'd1000;
    localparam logic [PITCH_W-1:0]   THRESHOLD_RESET   = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE_THRESHOLD  = 2'd0,
        CFG_DISABLE_THRESHOLD = 2'd1,
        CFG_HOLD_MS           = 2'd2,
        CFG_ALPHA             = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic signed [PITCH_W-1:0] enable_threshold;
        logic signed [PITCH_W-1:0] disable_threshold;
        logic [TIMEOUT_W-1:0]      hold_ms;
        logic [ALPHA_W-1:0]        alpha;
    } cfg_t;

    typedef struct packed {
        logic                      kind;
        logic signed [PITCH_W-1:0] pitch;
        logic [TIME_W-1:0]         time_ms;
    } item_t;

    typedef struct packed {
        logic                      climbing;
        logic                      drop_clear;
        logic signed [PITCH_W-1:0] bias_out;
    } result_t;

endpackage

/* hw/rtl/tcd_if.sv */
interface tcd_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic signed [tcd_pkg::PITCH_W-1:0]   pitch;
    logic [tcd_pkg::TIME_W-1:0]           time_ms;

    modport source (output valid, kind, pitch, time_ms, input ready);
    modport sink (input valid, kind, pitch, time_ms, output ready);
endinterface

interface tcd_result_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 climbing;
    logic                                 drop_clear;
    logic signed [tcd_pkg::PITCH_W-1:0]   bias_out;

    modport source (output valid, climbing, drop_clear, bias_out, input ready);
    modport sink (input valid, climbing, drop_clear, bias_out, output ready);
endinterface

interface tcd_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [tcd_pkg::CFG_IDX_W-1:0]        index;
    logic [tcd_pkg::CFG_DATA_W-1:0]       data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* hw/rtl/tcd_cfg_regs.sv */
module tcd_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    tcd_cfg_if.sink       cfg,
    output tcd_pkg::cfg_t cfg_out
);

    tcd_pkg::cfg_t cfg_reg;

    assign cfg.ready = 1'b1;
    assign cfg_out   = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable_threshold  <= tcd_pkg::THRESHOLD_RESET;
            cfg_reg.disable_threshold <= tcd_pkg::THRESHOLD_RESET;
            cfg_reg.hold_ms           <= tcd_pkg::TIMEOUT_RESET;
            cfg_reg.alpha             <= tcd_pkg::ALPHA_RESET;
        end
        else if (cfg.valid)
        begin
            case (tcd_pkg::cfg_index_t'(cfg.index))
                tcd_pkg::CFG_ENABLE_THRESHOLD:
                    cfg_reg.enable_threshold <= cfg.data[tcd_pkg::PITCH_W-1:0];
                tcd_pkg::CFG_DISABLE_THRESHOLD:
                    cfg_reg.disable_threshold <= cfg.data[tcd_pkg::PITCH_W-1:0];
                tcd_pkg::CFG_HOLD_MS:
                    cfg_reg.hold_ms <= cfg.data[tcd_pkg::TIMEOUT_W-1:0];
                tcd_pkg::CFG_ALPHA:
                    cfg_reg.alpha <= cfg.data[tcd_pkg::ALPHA_W-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

endmodule

/* hw/rtl/tcd_core.sv */
module tcd_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             fire,
    input  tcd_pkg::item_t   item,
    input  tcd_pkg::cfg_t    cfg,
    output tcd_pkg::result_t res
);

    logic                                 climb_flag_reg, climb_flag_next;
    logic signed [tcd_pkg::PITCH_W-1:0]   pitch_bias_reg, pitch_bias_next;
    logic [tcd_pkg::TIME_W-1:0]           climb_start_reg, climb_start_next;

    logic signed [tcd_pkg::DIFF_W-1:0]    d;
    logic signed [tcd_pkg::DIFF_W-1:0]    diff;
    logic [tcd_pkg::TIME_W-1:0]           elapsed;
    logic                                 start_climb;
    logic                                 end_climb;
    logic                                 flag_a;
    logic signed [tcd_pkg::PITCH_W-1:0]   bias_a;
    logic [tcd_pkg::PITCH_W-1:0]          mag;
    logic [tcd_pkg::ALPHA_W-1:0]          weight;
    logic [tcd_pkg::PROD_W-1:0]           prod;
    logic [tcd_pkg::DIFF_W-1:0]           delta;
    logic [tcd_pkg::DIFF_W-1:0]           bias_sum;

    always_comb
    begin
        d = {item.pitch[tcd_pkg::PITCH_W-1], item.pitch}
            - {pitch_bias_reg[tcd_pkg::PITCH_W-1], pitch_bias_reg};
        elapsed     = item.time_ms - climb_start_reg;
        start_climb = !climb_flag_reg
            && (d < $signed({cfg.enable_threshold[tcd_pkg::PITCH_W-1],
                             cfg.enable_threshold}));
        end_climb   = climb_flag_reg
            && (d >= $signed({cfg.disable_threshold[tcd_pkg::PITCH_W-1],
                              cfg.disable_threshold}))
            && (elapsed > {{(tcd_pkg::TIME_W-tcd_pkg::TIMEOUT_W){1'b0}}, cfg.hold_ms});

        flag_a = (climb_flag_reg || start_climb) && !end_climb;
        bias_a = end_climb ? '0 : pitch_bias_reg;

        // follow pitch by exponential average, magnitude rounded toward zero
        diff = {item.pitch[tcd_pkg::PITCH_W-1], item.pitch}
            - {bias_a[tcd_pkg::PITCH_W-1], bias_a};
        mag  = diff[tcd_pkg::DIFF_W-1] ? tcd_pkg::PITCH_W'(-diff)
                                       : diff[tcd_pkg::PITCH_W-1:0];
        weight = (cfg.alpha > tcd_pkg::ALPHA_ONE) ? tcd_pkg::ALPHA_ONE : cfg.alpha;
        prod   = {{tcd_pkg::ALPHA_W{1'b0}}, mag} * {{tcd_pkg::PITCH_W{1'b0}}, weight};
        delta  = prod[tcd_pkg::ALPHA_SHIFT +: tcd_pkg::DIFF_W];
        bias_sum = diff[tcd_pkg::DIFF_W-1]
            ? {bias_a[tcd_pkg::PITCH_W-1], bias_a} - delta
            : {bias_a[tcd_pkg::PITCH_W-1], bias_a} + delta;

        if (item.kind)
        begin
            climb_flag_next  = 1'b0;
            pitch_bias_next  = '0;
            climb_start_next = climb_start_reg;
        end
        else
        begin
            climb_flag_next  = flag_a;
            pitch_bias_next  = flag_a ? bias_a : bias_sum[tcd_pkg::PITCH_W-1:0];
            climb_start_next = start_climb ? item.time_ms : climb_start_reg;
        end

        res.climbing   = climb_flag_next;
        res.drop_clear = item.kind || climb_flag_next;
        res.bias_out   = pitch_bias_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            climb_flag_reg  <= 1'b0;
            pitch_bias_reg  <= '0;
            climb_start_reg <= '0;
        end
        else if (fire)
        begin
            climb_flag_reg  <= climb_flag_next;
            pitch_bias_reg  <= pitch_bias_next;
            climb_start_reg <= climb_start_next;
        end
    end

endmodule

/* hw/rtl/tilt_climb_detector.sv */
// Tilt climb detector.
// Channels: sample (sink) takes tick and clear items carrying kind, pitch
// (signed Q4.12 rad) and time_ms; result (source) gives climbing, drop_clear
// and bias_out for every item, in order; cfg (sink) writes the four
// configuration registers by index and is always ready.
// An accepted item is held in an input register; the climb decision, the
// bias update (one 16x17 multiply) and the state write all happen when it
// moves on, as the result is loaded into the output register. Throughput:
// one item per cycle while result.ready stays high, limited by the update
// of the climb state and bias between the two registers.
// Reset clears the climb flag, bias and start time, empties both registers
// and restores the default thresholds, timeout and alpha.
// When the receiver stalls, the result holds in the output register and one
// further item may wait in the input register before sample.ready drops.
module tilt_climb_detector (
    input  logic          clk,
    input  logic          rst_n,
    tcd_sample_if.sink    sample,
    tcd_result_if.source  result,
    tcd_cfg_if.sink       cfg
);

    tcd_pkg::cfg_t    cfg_cur;
    tcd_pkg::result_t core_res;

    logic             s1_valid_reg;
    tcd_pkg::item_t   s1_item_reg;
    logic             out_valid_reg;
    tcd_pkg::result_t out_res_reg;

    logic             res_free;
    logic             s1_fire;
    logic             sample_fire;

    assign res_free    = !out_valid_reg || result.ready;
    assign s1_fire     = s1_valid_reg && res_free;
    assign sample.ready = !s1_valid_reg || s1_fire;
    assign sample_fire = sample.valid && sample.ready;

    tcd_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    tcd_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (s1_fire),
        .item  (s1_item_reg),
        .cfg   (cfg_cur),
        .res   (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.ready)
        begin
            s1_valid_reg <= sample.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_fire)
        begin
            s1_item_reg.kind    <= sample.kind;
            s1_item_reg.pitch   <= sample.pitch;
            s1_item_reg.time_ms <= sample.time_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            out_res_reg <= core_res;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.climbing   = out_res_reg.climbing;
    assign result.drop_clear = out_res_reg.drop_clear;
    assign result.bias_out   = out_res_reg.bias_out;

endmodule

/* bench/tb_tilt_climb_detector.sv */
module tb_tilt_climb_detector;
    import tcd_pkg::*;

    localparam int   QUIET_LIMIT = 2000;
    localparam int   PHASE_ITEMS = 172;
    localparam int   TAIL_CYCLES = 8;
    localparam int   REPORT_MAX  = 10;
    localparam logic KIND_TICK   = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    logic clk;
    logic rst_n;

    tcd_sample_if sample_ch();
    tcd_result_if result_ch();
    tcd_cfg_if    cfg_ch();

    tilt_climb_detector u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    item_t   sample_backlog[$];
    result_t climb_verdicts[$];

    logic                      climb_now   = 1'b0;
    logic signed [PITCH_W-1:0] bias_now    = '0;
    logic [TIME_W-1:0]         climb_t0    = '0;
    logic signed [PITCH_W-1:0] enable_lim  = THRESHOLD_RESET;
    logic signed [PITCH_W-1:0] disable_lim = THRESHOLD_RESET;
    logic [TIMEOUT_W-1:0]      hold_ms     = TIMEOUT_RESET;
    logic [ALPHA_W-1:0]        alpha_w     = ALPHA_RESET;

    int          idle_pct       = 8;
    bit          hold_sender    = 1'b0;
    bit          item_went      = 1'b0;
    int          mismatch_count = 0;
    int          quiet_cycles   = 0;
    int          items_taken    = 0;
    int          clears_taken   = 0;
    int          climbs_begun   = 0;
    int          climbs_ended   = 0;
    int          reg_writes     = 0;
    int          pitch_level    = 0;
    logic [31:0] clock_ms       = '0;

    function automatic logic signed [PITCH_W-1:0] bias_follow(
        input logic signed [PITCH_W-1:0] bias,
        input logic signed [PITCH_W-1:0] pitch
    );
        logic signed [DIFF_W-1:0] gap;
        logic [DIFF_W-1:0]        mag;
        logic [ALPHA_W-1:0]       w;
        logic [2*ALPHA_W-1:0]     prod;
        logic [PITCH_W-1:0]       step;
        gap  = {pitch[PITCH_W-1], pitch} - {bias[PITCH_W-1], bias};
        mag  = gap[DIFF_W-1] ? -gap : gap;
        w    = (alpha_w > ALPHA_ONE) ? ALPHA_ONE : alpha_w;
        prod = mag * w;
        step = prod[ALPHA_SHIFT +: PITCH_W];
        return gap[DIFF_W-1] ? bias - step : bias + step;
    endfunction

    function automatic result_t climb_step(input item_t it);
        logic signed [DIFF_W-1:0] gap;
        logic [TIME_W-1:0]        elapsed;
        result_t                  r;
        if (it.kind == KIND_CLEAR)
        begin
            climb_now    = 1'b0;
            bias_now     = '0;
            r.drop_clear = 1'b1;
            clears_taken++;
        end
        else
        begin
            gap = {it.pitch[PITCH_W-1], it.pitch} - {bias_now[PITCH_W-1], bias_now};
            if (!climb_now && gap < enable_lim)
            begin
                climb_now = 1'b1;
                climb_t0  = it.time_ms;
                climbs_begun++;
            end
            else if (climb_now && gap >= disable_lim)
            begin
                elapsed = it.time_ms - climb_t0;
                if (elapsed > hold_ms)
                begin
                    climb_now = 1'b0;
                    bias_now  = '0;
                    climbs_ended++;
                end
            end
            if (!climb_now)
                bias_now = bias_follow(bias_now, it.pitch);
            r.drop_clear = climb_now;
        end
        r.climbing = climb_now;
        r.bias_out = bias_now;
        return r;
    endfunction

    function automatic logic signed [PITCH_W-1:0] pick_limit();
        case ($urandom_range(9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'($urandom);
            default: return 16'(int'($urandom_range(8000)) - 4000);
        endcase
    endfunction

    function automatic logic [TIMEOUT_W-1:0] pick_timeout();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            default: return 16'($urandom_range(3000));
        endcase
    endfunction

    function automatic logic [ALPHA_W-1:0] pick_alpha();
        case ($urandom_range(9))
            0:       return '0;
            1:       return ALPHA_ONE;
            2:       return '1;
            3:       return 17'($urandom_range(131071, 65537));
            default: return 17'($urandom_range(65535));
        endcase
    endfunction

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
    endtask

    task automatic load_settings(
        input logic signed [PITCH_W-1:0] en,
        input logic signed [PITCH_W-1:0] dis,
        input logic [TIMEOUT_W-1:0]      tmo,
        input logic [ALPHA_W-1:0]        a
    );
        write_reg(CFG_ENABLE_THRESHOLD, {1'($urandom), en});
        write_reg(CFG_DISABLE_THRESHOLD, {1'($urandom), dis});
        write_reg(CFG_HOLD_MS, {1'($urandom), tmo});
        write_reg(CFG_ALPHA, a);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic push_tick(input int p, input logic [TIME_W-1:0] t);
        item_t it;
        it.kind    = KIND_TICK;
        it.pitch   = 16'(p);
        it.time_ms = t;
        sample_backlog.insert(sample_backlog.size(), it);
    endtask

    task automatic push_clear();
        item_t it;
        it.kind    = KIND_CLEAR;
        it.pitch   = 16'($urandom);
        it.time_ms = $urandom;
        sample_backlog.insert(sample_backlog.size(), it);
    endtask

    // mostly noisy pitch around a level that jumps now and then, time mostly rising
    task automatic queue_random(input int count);
        int    v;
        int    roll;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(99);
            if (roll < 3)
                push_clear();
            else
            begin
                if ($urandom_range(15) == 0)
                    pitch_level = int'($urandom_range(65535)) - 32768;
                if (roll < 20)
                    v = int'($urandom_range(65535)) - 32768;
                else
                    v = pitch_level + int'($urandom_range(1200)) - 600;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                case ($urandom_range(49))
                    0, 1:    clock_ms = $urandom;
                    2:       clock_ms = 32'hFFFF_FFFF - $urandom_range(3000);
                    default: clock_ms = clock_ms + $urandom_range(hold_ms / 3 + 30);
                endcase
                push_tick(v, clock_ms);
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || sample_ch.valid || climb_verdicts.size() != 0);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(negedge clk)
    begin : drive_samples
        item_t nxt;
        if (!rst_n)
            sample_ch.valid <= 1'b0;
        else if (!sample_ch.valid || item_went)
        begin
            if (sample_backlog.size() != 0 && !hold_sender && $urandom_range(99) >= idle_pct)
            begin
                nxt = sample_backlog.pop_front();
                sample_ch.valid   <= 1'b1;
                sample_ch.kind    <= nxt.kind;
                sample_ch.pitch   <= nxt.pitch;
                sample_ch.time_ms <= nxt.time_ms;
            end
            else
                sample_ch.valid <= 1'b0;
        end
    end

    always @(negedge clk)
        result_ch.ready <= !rst_n || ($urandom_range(99) >= idle_pct);

    always @(posedge clk)
    begin : watch_channels
        item_t   got;
        result_t want;
        result_t seen;
        if (rst_n)
        begin
            item_went <= sample_ch.valid && sample_ch.ready;
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_index_t'(cfg_ch.index))
                    CFG_ENABLE_THRESHOLD:  enable_lim  = cfg_ch.data[PITCH_W-1:0];
                    CFG_DISABLE_THRESHOLD: disable_lim = cfg_ch.data[PITCH_W-1:0];
                    CFG_HOLD_MS:           hold_ms     = cfg_ch.data[TIMEOUT_W-1:0];
                    CFG_ALPHA:             alpha_w     = cfg_ch.data[ALPHA_W-1:0];
                    default:               ;
                endcase
                reg_writes++;
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                got.kind    = sample_ch.kind;
                got.pitch   = sample_ch.pitch;
                got.time_ms = sample_ch.time_ms;
                climb_verdicts.insert(climb_verdicts.size(), climb_step(got));
                items_taken++;
            end
            if (result_ch.valid && result_ch.ready)
            begin
                seen.climbing   = result_ch.climbing;
                seen.drop_clear = result_ch.drop_clear;
                seen.bias_out   = result_ch.bias_out;
                if (climb_verdicts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected result: climbing=%0b drop_clear=%0b bias=%0d",
                                 seen.climbing, seen.drop_clear, seen.bias_out);
                end
                else
                begin
                    want = climb_verdicts.pop_front();
                    if (seen.climbing !== want.climbing || seen.drop_clear !== want.drop_clear
                        || seen.bias_out !== want.bias_out)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display(
                                "mismatch exp/act: climbing %0b/%0b drop %0b/%0b bias %0d/%0d",
                                want.climbing, seen.climbing, want.drop_clear,
                                seen.drop_clear, want.bias_out, seen.bias_out);
                    end
                end
            end
            if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("no handshake for %0d cycles, run stopped", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : stimulus
        rst_n             = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_ENABLE_THRESHOLD;
        cfg_ch.data       = '0;
        clock_ms          = $urandom;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: entry, exit at exactly the timeout and one past it, wrap, clears
        push_tick(0, 32'd0);
        push_tick(32767, 32'd10);
        push_tick(-32768, 32'd20);
        push_tick(32767, 32'd500);
        push_tick(32767, 32'd1020);
        push_tick(32767, 32'd1021);
        push_clear();
        push_tick(-1, 32'hFFFF_FF00);
        push_tick(32767, 32'h0000_02E7);
        push_tick(32767, 32'h0000_02E9);
        push_tick(-5000, 32'h0000_0400);
        push_clear();
        push_tick(1000, 32'h0000_0500);
        wait_drained();

        load_settings(-32768, 32767, 16'd0, ALPHA_ONE);
        push_tick(32767, 32'd1);
        push_tick(-32768, 32'd2);
        push_tick(32767, 32'd3);
        push_clear();
        push_tick(32767, 32'd5);
        push_tick(-1, 32'd6);
        wait_drained();

        load_settings(32767, -32768, 16'hFFFF, '1);
        push_tick(100, 32'd0);
        push_tick(-32768, 32'd65535);
        push_tick(0, 32'd65536);
        push_tick(32767, 32'd70000);
        push_tick(-32768, 32'd70001);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            load_settings(pick_limit(), pick_limit(), pick_timeout(), pick_alpha());
            idle_pct = (phase == 2) ? 0 : 8;
            queue_random(PHASE_ITEMS);
            if (phase == 1)
            begin
                while (sample_backlog.size() > PHASE_ITEMS / 2)
                    @(negedge clk);
                hold_sender = 1'b1;
                do
                    @(negedge clk);
                while (sample_ch.valid || climb_verdicts.size() != 0);
                hold_sender = 1'b0;
            end
            wait_drained();
        end
        idle_pct = 8;
        repeat (TAIL_CYCLES) @(posedge clk);
        mismatch_count += climb_verdicts.size();

        $display("Run covered %0d items, %0d of them clear requests, with %0d register writes.",
                 items_taken, clears_taken, reg_writes);
        $display("Climbs entered: %0d, climbs left after the timeout: %0d, mismatches: %0d.",
                 climbs_begun, climbs_ended, mismatch_count);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/tcd_pkg.sv
hw/rtl/tcd_if.sv
hw/rtl/tcd_cfg_regs.sv
hw/rtl/tcd_core.sv
hw/rtl/tilt_climb_detector.sv
bench/tb_tilt_climb_detector.sv
